// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for checker files (included by cfl_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CFL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked at every edge, reset included.
`define CFL_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: assertion failed");

`endif

// ----- hw/rtl/cfl_pkg.sv -----
package cfl_pkg;

  localparam int CFG_W            = 12;
  localparam int COORD_W          = 11;
  localparam int TEX_W            = 11;
  localparam int FACE_W           = 3;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;
  localparam int DEF_MAX_FACE_DIM = 2048;
  localparam int DEF_FRAC_BITS    = 16;
  localparam int RESET_DIM        = 512;

  localparam logic REG_FACE_WIDTH  = 1'b0;
  localparam logic REG_FACE_HEIGHT = 1'b1;

  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_UP     = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

  typedef struct packed {
    logic neg_x;
    logic sat_x;
    logic neg_y;
    logic sat_y;
  } norm_side_t;

  typedef struct packed {
    logic              in_circle;
    logic [FACE_W-1:0] face;
    logic              s_neg;
    logic              t_neg;
  } face_side_t;

endpackage

// ----- hw/rtl/cfl_div_pipe.sv -----
module cfl_div_pipe
  import cfl_pkg::*;
#(
  parameter int DW = 12,
  parameter int QB = 17,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW:0]   in_num_a,
  input  logic [DW-1:0] in_den_a,
  input  logic [DW:0]   in_num_b,
  input  logic [DW-1:0] in_den_b,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_q_a,
  output logic [QB-1:0] out_q_b,
  output logic [SW-1:0] out_side
);

  // one quotient bit per stage; numerator must be below twice the divisor
  logic [DW:0]   rem_a_r  [QB];
  logic [DW:0]   rem_b_r  [QB];
  logic [DW-1:0] den_a_r  [QB];
  logic [DW-1:0] den_b_r  [QB];
  logic [QB-1:0] q_a_r    [QB];
  logic [QB-1:0] q_b_r    [QB];
  logic [SW-1:0] side_r   [QB];
  logic          valid_r  [QB];

  function automatic logic [DW+1:0] div_step(input logic [DW:0] r, input logic [DW-1:0] d);
    logic        ge;
    logic [DW:0] rn;
    ge = r >= {1'b0, d};
    rn = ge ? r - {1'b0, d} : r;
    return {ge, rn};
  endfunction

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [DW:0]   ra_in, rb_in;
    logic [DW-1:0] da_in, db_in;
    logic [QB-1:0] qa_in, qb_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [DW+1:0] sa, sb;

    if (g == 0) begin : g_first
      assign ra_in = in_num_a;
      assign rb_in = in_num_b;
      assign da_in = in_den_a;
      assign db_in = in_den_b;
      assign qa_in = '0;
      assign qb_in = '0;
      assign s_in  = in_side;
      assign v_in  = in_valid;
    end else begin : g_next
      assign ra_in = {rem_a_r[g-1][DW-1:0], 1'b0};
      assign rb_in = {rem_b_r[g-1][DW-1:0], 1'b0};
      assign da_in = den_a_r[g-1];
      assign db_in = den_b_r[g-1];
      assign qa_in = q_a_r[g-1];
      assign qb_in = q_b_r[g-1];
      assign s_in  = side_r[g-1];
      assign v_in  = valid_r[g-1];
    end

    assign sa = div_step(ra_in, da_in);
    assign sb = div_step(rb_in, db_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a_r[g] <= sa[DW:0];
        rem_b_r[g] <= sb[DW:0];
        den_a_r[g] <= da_in;
        den_b_r[g] <= db_in;
        q_a_r[g]   <= {qa_in[QB-2:0], sa[DW+1]};
        q_b_r[g]   <= {qb_in[QB-2:0], sb[DW+1]};
        side_r[g]  <= s_in;
      end
    end
  end

  assign out_valid = valid_r[QB-1];
  assign out_q_a   = q_a_r[QB-1];
  assign out_q_b   = q_b_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

// ----- hw/rtl/cfl_sqrt_pipe.sv -----
module cfl_sqrt_pipe
  import cfl_pkg::*;
#(
  parameter int F  = 16,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*F:0]    in_n,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [F:0]      out_root,
  output logic [SW-1:0]   out_side
);

  localparam int NW = 2 * F + 1;
  localparam int ST = F + 1;

  logic [NW-1:0] n_r     [ST];
  logic [NW-1:0] res_r   [ST];
  logic [SW-1:0] side_r  [ST];
  logic          valid_r [ST];

  for (genvar g = 0; g < ST; g++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (F - g));
    logic [NW-1:0] n_in, res_in, n_out, res_out;
    logic [NW:0]   trial;
    logic [SW-1:0] s_in;
    logic          v_in;

    if (g == 0) begin : g_first
      assign n_in   = in_n;
      assign res_in = '0;
      assign s_in   = in_side;
      assign v_in   = in_valid;
    end else begin : g_next
      assign n_in   = n_r[g-1];
      assign res_in = res_r[g-1];
      assign s_in   = side_r[g-1];
      assign v_in   = valid_r[g-1];
    end

    assign trial = (NW+1)'(res_in) + (NW+1)'(BIT);

    always_comb begin
      if ((NW+1)'(n_in) >= trial) begin
        n_out   = n_in - trial[NW-1:0];
        res_out = (res_in >> 1) + BIT;
      end else begin
        n_out   = n_in;
        res_out = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[g]    <= n_out;
        res_r[g]  <= res_out;
        side_r[g] <= s_in;
      end
    end
  end

  assign out_valid = valid_r[ST-1];
  assign out_root  = res_r[ST-1][F:0];
  assign out_side  = side_r[ST-1];

endmodule

// ----- hw/rtl/cubemap_fisheye_lookup_unit.sv -----
// Cube-map to fisheye lookup: one fisheye pixel coordinate in, one texel address out.
// Input channel in_valid/in_ready carries in_pixel_col and in_pixel_row. Result
// channel out_valid/out_ready carries out_inside_res, out_face, out_texel_u and
// out_texel_v; pixels outside the unit circle return inside 0 and zero fields.
// Face width and height are written over the APB port (0x0 width, 0x4 height);
// the user must write them only while no beat is in flight, as the block does not
// enforce it; out-of-range values are saturated to [2, max]. Two bit-per-stage
// dividers and a bit-per-stage square root set the pipeline depth. Throughput is
// one beat per cycle unless the receiver stalls; every stage carries its own valid
// bit. When the receiver stalls the whole pipeline holds and in_ready drops, so no
// beat is lost or repeated; bubbles hold too until out_ready returns.
// Synchronous reset clears all valid bits and loads 512 into both size registers.
module cubemap_fisheye_lookup_unit
  import cfl_pkg::*;
#(
  parameter int MAX_FACE_DIM = DEF_MAX_FACE_DIM,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_pixel_col,
  input  logic [COORD_W-1:0] in_pixel_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_inside_res,
  output logic [FACE_W-1:0]  out_face,
  output logic [TEX_W-1:0]   out_texel_u,
  output logic [TEX_W-1:0]   out_texel_v,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int F     = FRAC_BITS;
  localparam int DIM_W = $clog2(MAX_FACE_DIM + 1);
  localparam int EW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int DXW   = EW + 2;
  localparam int NW    = 2 * F + 1;
  localparam int SQW   = 2 * F + 4;
  localparam int SQSW  = 3 + 2 * (F + 1);

  localparam logic [F+1:0]  ONE_X  = (F+2)'(1) << F;
  localparam logic [F+1:0]  TWO_X  = (F+2)'(2) << F;
  localparam logic [SQW:0]  ONE_SQ = (SQW+1)'(1) << (2 * F);

  // configuration
  logic [CFG_W-1:0] face_width_r, face_height_r;
  logic             cfg_wr;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_width_r  <= CFG_W'(RESET_DIM);
      face_height_r <= CFG_W'(RESET_DIM);
    end else if (cfg_wr) begin
      if (reg_idx == REG_FACE_WIDTH) begin
        face_width_r <= pwdata[CFG_W-1:0];
      end
      if (reg_idx == REG_FACE_HEIGHT) begin
        face_height_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FACE_WIDTH:  prdata = DATA_W'(face_width_r);
      REG_FACE_HEIGHT: prdata = DATA_W'(face_height_r);
      default:         prdata = '0;
    endcase
  end

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [EW-1:0] re;
    re = EW'(r);
    if (re < EW'(2)) begin
      return DIM_W'(2);
    end else if (re > EW'(MAX_FACE_DIM)) begin
      return DIM_W'(MAX_FACE_DIM);
    end else begin
      return DIM_W'(re);
    end
  endfunction

  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = eff_dim(face_width_r);
  assign h_eff = eff_dim(face_height_r);

  // global advance
  logic en;
  logic out_valid_r;
  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  // stage P0: centered numerators
  function automatic logic [DXW+1:0] center(input logic [COORD_W-1:0] c,
                                            input logic [DIM_W-1:0] d);
    logic [DXW-1:0] dx, mag;
    logic           neg, sat;
    dx  = DXW'({c, 1'b0}) - DXW'(d);
    neg = dx[DXW-1];
    mag = neg ? (~dx + DXW'(1)) : dx;
    sat = mag >= DXW'({d, 1'b0});
    return {neg, sat, mag};
  endfunction

  logic [DXW+1:0] cx_nxt, cy_nxt;
  logic           p0_valid_r;
  norm_side_t     p0_side_r;
  logic [DIM_W:0] p0_num_x_r, p0_num_y_r;

  assign cx_nxt = center(in_pixel_col, w_eff);
  assign cy_nxt = center(in_pixel_row, h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (en) begin
      p0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_side_r.neg_x <= cx_nxt[DXW+1];
      p0_side_r.sat_x <= cx_nxt[DXW];
      p0_side_r.neg_y <= cy_nxt[DXW+1];
      p0_side_r.sat_y <= cy_nxt[DXW];
      p0_num_x_r      <= cx_nxt[DXW] ? '0 : cx_nxt[DIM_W:0];
      p0_num_y_r      <= cy_nxt[DXW] ? '0 : cy_nxt[DIM_W:0];
    end
  end

  // normalize x, y
  logic           d1_valid;
  logic [F:0]     d1_qx, d1_qy;
  logic [3:0]     d1_side_raw;
  norm_side_t     d1_side;

  cfl_div_pipe #(.DW(DIM_W), .QB(F + 1), .SW($bits(norm_side_t))) u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p0_valid_r),
    .in_num_a  (p0_num_x_r),
    .in_den_a  (w_eff),
    .in_num_b  (p0_num_y_r),
    .in_den_b  (h_eff),
    .in_side   (p0_side_r),
    .out_valid (d1_valid),
    .out_q_a   (d1_qx),
    .out_q_b   (d1_qy),
    .out_side  (d1_side_raw)
  );
  assign d1_side = d1_side_raw;

  // stage A: magnitudes and squares
  logic [F+1:0]   ax_nxt, ay_nxt;
  logic           a_valid_r, a_sx_r, a_sy_r;
  logic [F+1:0]   a_ax_r, a_ay_r;
  logic [SQW-1:0] a_sqx_r, a_sqy_r;

  assign ax_nxt = d1_side.sat_x ? TWO_X : {1'b0, d1_qx};
  assign ay_nxt = d1_side.sat_y ? TWO_X : {1'b0, d1_qy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax_r  <= ax_nxt;
      a_ay_r  <= ay_nxt;
      a_sx_r  <= d1_side.neg_x;
      a_sy_r  <= d1_side.neg_y;
      a_sqx_r <= SQW'(ax_nxt) * SQW'(ax_nxt);
      a_sqy_r <= SQW'(ay_nxt) * SQW'(ay_nxt);
    end
  end

  // stage B: circle test
  logic [SQW:0]   r2_nxt, rem_nxt;
  logic           b_valid_r, b_inside_r, b_sx_r, b_sy_r;
  logic [NW-1:0]  b_n_r;
  logic [F:0]     b_ax_r, b_ay_r;

  assign r2_nxt  = (SQW+1)'(a_sqx_r) + (SQW+1)'(a_sqy_r);
  assign rem_nxt = ONE_SQ - r2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_inside_r <= r2_nxt <= ONE_SQ;
      b_n_r      <= (r2_nxt <= ONE_SQ) ? rem_nxt[NW-1:0] : '0;
      b_ax_r     <= a_ax_r[F:0];
      b_ay_r     <= a_ay_r[F:0];
      b_sx_r     <= a_sx_r;
      b_sy_r     <= a_sy_r;
    end
  end

  // z
  logic            s1_valid;
  logic [F:0]      s1_z;
  logic [SQSW-1:0] s1_side;
  logic            s1_inside, s1_sx, s1_sy;
  logic [F:0]      s1_ax, s1_ay;

  cfl_sqrt_pipe #(.F(F), .SW(SQSW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .in_n      (b_n_r),
    .in_side   ({b_inside_r, b_sx_r, b_sy_r, b_ax_r, b_ay_r}),
    .out_valid (s1_valid),
    .out_root  (s1_z),
    .out_side  (s1_side)
  );
  assign {s1_inside, s1_sx, s1_sy, s1_ax, s1_ay} = s1_side;

  // stage C: major axis and face
  logic [F:0]  mx_nxt, ma_nxt, scm_nxt, tcm_nxt;
  logic        sneg_nxt, tneg_nxt;
  logic [FACE_W-1:0] face_nxt;
  logic        c_valid_r;
  logic [F:0]  c_ma_r;
  logic [F+1:0] c_sc_r, c_tc_r;
  face_side_t  c_side_r;

  always_comb begin
    mx_nxt = (s1_ay > s1_ax) ? s1_ay : s1_ax;
    if (s1_z > mx_nxt) begin
      ma_nxt   = s1_z;
      scm_nxt  = s1_ax;
      sneg_nxt = s1_sx;
      tcm_nxt  = s1_ay;
      tneg_nxt = ~s1_sy;
      face_nxt = FACE_FRONT;
    end else if (s1_ay > s1_ax) begin
      ma_nxt   = s1_ay;
      scm_nxt  = s1_ax;
      sneg_nxt = s1_sx;
      tcm_nxt  = s1_z;
      tneg_nxt = s1_sy;
      face_nxt = s1_sy ? FACE_UP : FACE_BOTTOM;
    end else begin
      ma_nxt   = s1_ax;
      scm_nxt  = s1_z;
      sneg_nxt = ~s1_sx;
      tcm_nxt  = s1_ay;
      tneg_nxt = ~s1_sy;
      face_nxt = s1_sx ? FACE_LEFT : FACE_RIGHT;
    end
    if (ma_nxt == '0) begin
      ma_nxt = ONE_X[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ma_r             <= ma_nxt;
      c_sc_r             <= {1'b0, scm_nxt};
      c_tc_r             <= {1'b0, tcm_nxt};
      c_side_r.in_circle <= s1_inside;
      c_side_r.face      <= face_nxt;
      c_side_r.s_neg     <= sneg_nxt;
      c_side_r.t_neg     <= tneg_nxt;
    end
  end

  // project onto the face
  logic       d2_valid;
  logic [F:0] d2_qs, d2_qt;
  logic [$bits(face_side_t)-1:0] d2_side_raw;
  face_side_t d2_side;

  cfl_div_pipe #(.DW(F + 1), .QB(F + 1), .SW($bits(face_side_t))) u_proj_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid_r),
    .in_num_a  (c_sc_r),
    .in_den_a  (c_ma_r),
    .in_num_b  (c_tc_r),
    .in_den_b  (c_ma_r),
    .in_side   (c_side_r),
    .out_valid (d2_valid),
    .out_q_a   (d2_qs),
    .out_q_b   (d2_qt),
    .out_side  (d2_side_raw)
  );
  assign d2_side = d2_side_raw;

  // stage D: map to [0, ONE]
  logic [F+1:0] s_sum_nxt, t_sum_nxt;
  logic [F:0]   t_nxt;
  logic         d_valid_r, d_inside_r;
  logic [FACE_W-1:0] d_face_r;
  logic [F:0]   d_s_r, d_tm_r;

  assign s_sum_nxt = d2_side.s_neg ? (ONE_X - {1'b0, d2_qs}) : (ONE_X + {1'b0, d2_qs});
  assign t_sum_nxt = d2_side.t_neg ? (ONE_X - {1'b0, d2_qt}) : (ONE_X + {1'b0, d2_qt});
  assign t_nxt     = t_sum_nxt[F+1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s_r      <= s_sum_nxt[F+1:1];
      d_tm_r     <= ONE_X[F:0] - t_nxt;
      d_inside_r <= d2_side.in_circle;
      d_face_r   <= d2_side.face;
    end
  end

  // stage E: scale to texels
  logic         e_valid_r, e_inside_r;
  logic [FACE_W-1:0] e_face_r;
  logic [F+DIM_W:0]  e_pu_r, e_pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_pu_r     <= (F+DIM_W+1)'(d_s_r) * (F+DIM_W+1)'(w_eff);
      e_pv_r     <= (F+DIM_W+1)'(d_tm_r) * (F+DIM_W+1)'(h_eff);
      e_inside_r <= d_inside_r;
      e_face_r   <= d_face_r;
    end
  end

  // output register: clamp to the face edge
  logic [DIM_W:0]   u_sh, v_sh;
  logic [DIM_W-1:0] w_m1, h_m1, u_cl, v_cl;
  logic             out_inside_r;
  logic [FACE_W-1:0] out_face_r;
  logic [TEX_W-1:0] out_u_r, out_v_r;

  assign u_sh = e_pu_r[F+DIM_W:F];
  assign v_sh = e_pv_r[F+DIM_W:F];
  assign w_m1 = w_eff - DIM_W'(1);
  assign h_m1 = h_eff - DIM_W'(1);
  assign u_cl = (u_sh > {1'b0, w_m1}) ? w_m1 : u_sh[DIM_W-1:0];
  assign v_cl = (v_sh > {1'b0, h_m1}) ? h_m1 : v_sh[DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_r <= e_inside_r;
      out_face_r   <= e_inside_r ? e_face_r : FACE_LEFT;
      out_u_r      <= e_inside_r ? TEX_W'(u_cl) : '0;
      out_v_r      <= e_inside_r ? TEX_W'(v_cl) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_face       = out_face_r;
  assign out_texel_u    = out_u_r;
  assign out_texel_v    = out_v_r;

endmodule

// ----- hw/rtl/cfl_checker.sv -----
`include "assert_macros.svh"

module cfl_checker
  import cfl_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_inside_res,
  input logic [FACE_W-1:0]  out_face,
  input logic [TEX_W-1:0]   out_texel_u,
  input logic [TEX_W-1:0]   out_texel_v
);

  `CFL_ASSERT_NR(a_reset_empty, clk, $past(!rst_n) |-> !out_valid)

  `CFL_ASSERT(a_stall_backs_up, clk, rst_n, out_valid && !out_ready |-> !in_ready)

  `CFL_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_face) && $stable(out_texel_u) && $stable(out_texel_v))

  `CFL_ASSERT(a_outside_zero, clk, rst_n, out_valid && !out_inside_res |-> out_face == FACE_LEFT && out_texel_u == '0 && out_texel_v == '0)

  `CFL_ASSERT(a_face_legal, clk, rst_n, out_valid && out_inside_res |-> out_face <= FACE_BOTTOM)

endmodule

bind cubemap_fisheye_lookup_unit cfl_checker u_cfl_checker (.*);
